@@ sv/dts_pkg.sv @@
package dts_pkg;
    localparam int SLOTS = 16;
    localparam int SW = 4;
    localparam int ENGINES = 4;
    localparam int EW = 2;
    localparam int DSLOTS = 16;
    localparam int DW = 4;
    localparam int SLOT_BITS = 6 + 2 + 64 + 16 + 16;
    localparam int IN_W = 2 + 7 + 3 + 64 + 16 + 16 + 4;
    localparam int IN_BYTES_W = 120;
    localparam int OUT_W = 1 + 6 + 2 + 64 + 16 + 16 + 4 + 4;
    localparam int OUT_BYTES_W = 120;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_ISSUE = 2'd1,
        OP_FINISH = 2'd2,
        OP_RETIRE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_PENDING = 2'd1,
        ST_ISSUED = 2'd2,
        ST_FINISHED = 2'd3
    } t_slot_st;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_MIN,
        S_ISSUE_RD,
        S_ISSUE_CHK,
        S_FIN_SCAN,
        S_RET_SCAN,
        S_RET_DONE,
        S_RET_FREE,
        S_OUT
    } t_state;
endpackage

@@ sv/dts_ram.sv @@
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/dependency_task_scheduler.sv @@
// channel  | dir | fields (low bit first)
// s_axis   | in  | op, cmd, engine, deps, epoch, seq_tag, status
// m_axis   | out | accepted, out_cmd, out_engine, out_deps, out_epoch,
//          |     | out_sequence, out_status, stall_reasons
// cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data (credit per engine)
// Issue, finish and retire work by sequential scans of the 16-entry slot RAM read port,
// one entry a cycle; submit writes a free slot without a scan.
// Reset is synchronous; slot data RAM needs no clearing (states live in flops).
// s_axis_tready is low from acceptance until the result is taken on m_axis.
module dependency_task_scheduler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // op, cmd, engine, deps, epoch, seq_tag, status
    input  logic [dts_pkg::IN_BYTES_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // accepted, out_cmd, out_engine, out_deps, out_epoch,
    // out_sequence, out_status, stall_reasons
    output logic [dts_pkg::OUT_BYTES_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [dts_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [7:0]                      i_cfg_data
);
    import dts_pkg::*;

    t_state r_state, n_state;
    logic [IN_W-1:0] r_in, n_in;
    logic [7:0] r_credit [ENGINES];
    t_slot_st r_sst [SLOTS], n_sst [SLOTS];
    logic [63:0] r_cc, n_cc;
    logic [7:0] r_infl [ENGINES], n_infl [ENGINES];
    logic [4:0] r_pend, n_pend;
    logic [DSLOTS-1:0] r_dv, n_dv;
    logic [19:0] r_dd [DSLOTS], n_dd [DSLOTS];
    logic [4:0] r_dcnt, n_dcnt;
    logic [SW:0] r_i, n_i;
    logic [SW:0] r_j, n_j;
    logic [SW:0] r_old, n_old;
    logic r_has, n_has;
    logic [15:0] r_min, n_min;
    logic [15:0] r_oseq, n_oseq;
    logic [3:0] r_stall, n_stall;
    logic [3:0] r_ost, n_ost;
    logic [OUT_W-1:0] r_out, n_out;

    logic ram_we;
    logic [SW-1:0] ram_wa, ram_ra;
    logic [SLOT_BITS-1:0] ram_wd, ram_rd;

    dts_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(ram_wd),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    logic [6:0] in_cmd;
    logic [2:0] in_eng;
    logic [63:0] in_dep;
    logic [15:0] in_ep, in_seq;
    logic [3:0] in_st;
    assign in_cmd = r_in[8:2];
    assign in_eng = r_in[11:9];
    assign in_dep = r_in[75:12];
    assign in_ep = r_in[91:76];
    assign in_seq = r_in[107:92];
    assign in_st = r_in[111:108];

    logic [5:0] rd_cmd;
    logic [1:0] rd_eng;
    logic [63:0] rd_dep;
    logic [15:0] rd_ep, rd_seq;
    assign rd_cmd = ram_rd[5:0];
    assign rd_eng = ram_rd[7:6];
    assign rd_dep = ram_rd[71:8];
    assign rd_ep = ram_rd[87:72];
    assign rd_seq = ram_rd[103:88];

    // index of the slot whose RAM data is on ram_rd (read issued previous cycle)
    logic [SW-1:0] r_ridx;
    always_ff @(posedge i_clk) r_ridx <= ram_ra;

    logic [SW-1:0] free_idx;
    logic free_ok;
    logic [DW-1:0] dfree;
    logic dfree_ok;
    always_comb begin
        free_idx = '0;
        free_ok = 1'b0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (r_sst[k] == ST_EMPTY) begin
                free_idx = SW'(k);
                free_ok = 1'b1;
            end
        end
        dfree = '0;
        dfree_ok = 1'b0;
        for (int k = DSLOTS - 1; k >= 0; k--) begin
            if (!r_dv[k]) begin
                dfree = DW'(k);
                dfree_ok = 1'b1;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {{(OUT_BYTES_W - OUT_W){1'b0}}, r_out};

    always_comb begin
        n_state = r_state;
        n_in = r_in;
        n_sst = r_sst;
        n_cc = r_cc;
        n_infl = r_infl;
        n_pend = r_pend;
        n_dv = r_dv;
        n_dd = r_dd;
        n_dcnt = r_dcnt;
        n_i = r_i;
        n_j = r_j;
        n_old = r_old;
        n_has = r_has;
        n_min = r_min;
        n_oseq = r_oseq;
        n_stall = r_stall;
        n_ost = r_ost;
        n_out = r_out;
        ram_we = 1'b0;
        ram_wa = free_idx;
        ram_wd = {in_seq, in_ep, in_dep, in_eng[1:0], in_cmd[5:0]};
        ram_ra = r_i[SW-1:0];
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_in = s_axis_tdata[IN_W-1:0];
                    n_out = '0;
                    n_i = '0;
                    n_j = '0;
                    n_has = 1'b0;
                    n_stall = '0;
                    case (t_op'(s_axis_tdata[1:0]))
                        OP_SUBMIT: n_state = S_SCAN_MIN;
                        OP_ISSUE: n_state = S_ISSUE_RD;
                        OP_FINISH: n_state = S_FIN_SCAN;
                        default: n_state = S_RET_SCAN;
                    endcase
                    if (t_op'(s_axis_tdata[1:0]) == OP_SUBMIT) begin
                        n_state = S_OUT;
                        if (s_axis_tdata[8] == 1'b0 && s_axis_tdata[11:9] < 3'(ENGINES)
                                && free_ok) begin
                            n_state = S_SCAN_MIN;
                        end
                    end
                    if (t_op'(s_axis_tdata[1:0]) == OP_ISSUE && r_dcnt >= 5'(DSLOTS)) begin
                        n_out[OUT_W-1 -: 4] = 4'b0001;
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN_MIN: begin
                // submit write
                ram_we = 1'b1;
                n_sst[free_idx] = ST_PENDING;
                n_pend = r_pend + 5'd1;
                n_out[0] = 1'b1;
                n_state = S_OUT;
            end
            S_ISSUE_RD: begin
                // find next pending candidate at or after r_i
                if (r_i == (SW+1)'(SLOTS)) begin
                    n_out[OUT_W-1 -: 4] = r_stall;
                    n_state = S_OUT;
                end else if (r_sst[r_i[SW-1:0]] == ST_PENDING) begin
                    n_j = '0;
                    n_has = 1'b0;
                    n_state = S_ISSUE_CHK;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_ISSUE_CHK: begin
                // r_j walks 0..SLOTS+1; data for candidate read first via r_j==0 cycle
                if (r_j == '0) begin
                    ram_ra = r_i[SW-1:0];
                    n_j = r_j + 1'b1;
                end else begin
                    ram_ra = r_j[SW-1:0] - 1'b1;
                    if (r_j == 1) begin
                        n_min = rd_ep;
                        n_oseq = rd_seq;
                        n_old = {1'b0, r_ridx};
                        n_out[6:1] = rd_cmd;
                        n_out[8:7] = rd_eng;
                        n_out[72:9] = rd_dep;
                        n_out[88:73] = rd_ep;
                        n_out[104:89] = rd_seq;
                    end else if (r_sst[r_ridx] != ST_EMPTY && rd_ep < r_min) begin
                        n_has = 1'b1;
                    end
                    if (r_j == (SW+1)'(SLOTS + 1)) begin
                        n_i = r_i + 1'b1;
                        n_state = S_ISSUE_RD;
                        if ((n_out[72:9] & ~r_cc) != '0) begin
                            n_stall[1] = 1'b1;
                        end else if (n_has) begin
                            n_stall[2] = 1'b1;
                        end else if (r_infl[n_out[8:7]] >= r_credit[n_out[8:7]]) begin
                            n_stall[3] = 1'b1;
                        end else begin
                            n_sst[r_i[SW-1:0]] = ST_ISSUED;
                            n_infl[n_out[8:7]] = r_infl[n_out[8:7]] + 8'd1;
                            if (r_pend != '0) n_pend = r_pend - 5'd1;
                            n_out[0] = 1'b1;
                            n_state = S_OUT;
                        end
                    end else begin
                        ram_ra = r_j[SW-1:0];
                        n_j = r_j + 1'b1;
                    end
                    if (r_j == (SW+1)'(SLOTS + 1) && !n_out[0]) begin
                        n_out[104:1] = '0;
                    end
                end
            end
            S_FIN_SCAN: begin
                ram_ra = r_j[SW-1:0];
                if (r_j != '0) begin
                    if (r_sst[r_ridx] == ST_ISSUED && rd_seq == in_seq) begin
                        n_state = S_OUT;
                        if (r_dcnt < 5'(DSLOTS) && dfree_ok) begin
                            n_dv[dfree] = 1'b1;
                            n_dd[dfree] = {in_st, in_seq};
                            n_dcnt = r_dcnt + 5'd1;
                            n_sst[r_ridx] = ST_FINISHED;
                            if (r_infl[rd_eng] != '0) n_infl[rd_eng] = r_infl[rd_eng] - 8'd1;
                            n_out[0] = 1'b1;
                        end
                    end else if (r_j == (SW+1)'(SLOTS)) begin
                        n_state = S_OUT;
                    end
                end
                if (n_state == S_FIN_SCAN) n_j = r_j + 1'b1;
            end
            S_RET_SCAN: begin
                ram_ra = r_j[SW-1:0];
                if (r_j != '0) begin
                    if (r_sst[r_ridx] != ST_EMPTY && (!r_has || rd_ep < r_min
                            || (rd_ep == r_min && rd_seq < r_oseq))) begin
                        n_has = 1'b1;
                        n_min = rd_ep;
                        n_oseq = rd_seq;
                        n_old = {1'b0, r_ridx};
                    end
                end
                if (r_j == (SW+1)'(SLOTS)) begin
                    n_state = S_OUT;
                    if (n_has && r_sst[n_old[SW-1:0]] == ST_FINISHED) begin
                        n_state = S_RET_DONE;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_RET_DONE: begin
                n_state = S_OUT;
                for (int k = DSLOTS - 1; k >= 0; k--) begin
                    if (r_dv[k] && r_dd[k][15:0] == r_oseq) begin
                        n_old[SW] = 1'b1;
                        n_ost = r_dd[k][19:16];
                        n_i = (SW+1)'(k);
                        n_state = S_RET_FREE;
                    end
                end
                n_j = '0;
            end
            S_RET_FREE: begin
                ram_ra = r_j[SW-1:0];
                if (r_j == '0) begin
                    n_dv[r_i[DW-1:0]] = 1'b0;
                    if (r_dcnt != '0) n_dcnt = r_dcnt - 5'd1;
                    n_j = r_j + 1'b1;
                end else begin
                    if (r_sst[r_ridx] == ST_FINISHED && rd_seq == r_oseq) begin
                        if (r_ost == 4'd0) n_cc[rd_cmd] = 1'b1;
                        n_sst[r_ridx] = ST_EMPTY;
                        n_out[0] = 1'b1;
                        n_out[104:89] = r_oseq;
                        n_out[108:105] = r_ost;
                        n_state = S_OUT;
                    end else if (r_j == (SW+1)'(SLOTS)) begin
                        n_state = S_OUT;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cc <= '0;
            r_pend <= '0;
            r_dv <= '0;
            r_dcnt <= '0;
            for (int k = 0; k < SLOTS; k++) r_sst[k] <= ST_EMPTY;
            for (int k = 0; k < ENGINES; k++) begin
                r_infl[k] <= '0;
                r_credit[k] <= 8'd1;
            end
        end else begin
            r_state <= n_state;
            r_cc <= n_cc;
            r_pend <= n_pend;
            r_dv <= n_dv;
            r_dcnt <= n_dcnt;
            r_sst <= n_sst;
            r_infl <= n_infl;
            if (i_cfg_we) r_credit[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        r_dd <= n_dd;
        r_i <= n_i;
        r_j <= n_j;
        r_old <= n_old;
        r_has <= n_has;
        r_min <= n_min;
        r_oseq <= n_oseq;
        r_stall <= n_stall;
        r_ost <= n_ost;
        r_out <= n_out;
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(r_out))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("accepting while result pending");
    a_dcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dcnt == 5'($countones(r_dv)))
        else $error("completion count mismatch");
    a_stall_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out[0] |-> r_out[OUT_W-1 -: 4] == 4'd0)
        else $error("stall bits on success");
endmodule
